>>> rtl/qatan_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qatan_pkg: shared types and constants
// Arctangent table, fixed-point scaling and per-item flags for the
// pipelined four-quadrant arctangent.
// ----------------------------------------------------------------------------
package qatan_pkg;

   // coordinates are scaled up by this many bits before the first rotation
   localparam int PRESHIFT   = 24;
   localparam int TABLE_SIZE = 32;
   // internal angle unit: a full turn is 2^ANGLE_BITS
   localparam int ANGLE_BITS = 32;

   // atan(2^-i), full turn = 2^32, rounded to nearest
   localparam logic [ANGLE_BITS-1:0] ATAN_TABLE [TABLE_SIZE] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81,
      32'd41,        32'd20,        32'd10,        32'd5,
      32'd3,         32'd1,         32'd1,         32'd0
   };

   // item flags carried down the pipeline beside the data
   typedef struct packed {
      logic       special;   // axis or origin: result is a fixed quarter count
      logic [1:0] quarters;  // fixed result in quarter turns
      logic       half;      // item was folded from the left half plane
   } qatan_flags_type;

endpackage

>>> rtl/qatan_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qatan_stage: one vectoring micro-rotation
// Rotate (x, y) toward the x axis by atan(2^-SHIFT), accumulate the angle,
// and hold the result in a register stage with its own valid bit.
// ----------------------------------------------------------------------------
module qatan_stage #(
   parameter int DATA_WIDTH = 51,
   parameter int SHIFT      = 0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         up_valid,
   output logic                         up_ready,
   input  logic signed [DATA_WIDTH-1:0] up_x,
   input  logic signed [DATA_WIDTH-1:0] up_y,
   input  logic [qatan_pkg::ANGLE_BITS-1:0] up_z,
   input  qatan_pkg::qatan_flags_type   up_flags,
   output logic                         dn_valid,
   input  logic                         dn_ready,
   output logic signed [DATA_WIDTH-1:0] dn_x,
   output logic signed [DATA_WIDTH-1:0] dn_y,
   output logic [qatan_pkg::ANGLE_BITS-1:0] dn_z,
   output qatan_pkg::qatan_flags_type   dn_flags
);
   import qatan_pkg::*;

   logic                         valid_ff;
   logic signed [DATA_WIDTH-1:0] x_ff, x_in;
   logic signed [DATA_WIDTH-1:0] y_ff, y_in;
   logic [ANGLE_BITS-1:0]        z_ff, z_in;
   qatan_flags_type              flags_ff;
   logic signed [DATA_WIDTH-1:0] dx;
   logic signed [DATA_WIDTH-1:0] dy;

   // arithmetic shifts floor toward minus infinity
   always_comb begin
      dx = up_y >>> SHIFT;
      dy = up_x >>> SHIFT;
      if (!up_y[DATA_WIDTH-1]) begin
         x_in = up_x + dx;
         y_in = up_y - dy;
         z_in = up_z + ATAN_TABLE[SHIFT];
      end else begin
         x_in = up_x - dx;
         y_in = up_y + dy;
         z_in = up_z - ATAN_TABLE[SHIFT];
      end
   end

   // advance when empty or when the next stage takes our item
   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         x_ff     <= x_in;
         y_ff     <= y_in;
         z_ff     <= z_in;
         flags_ff <= up_flags;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_x     = x_ff;
   assign dn_y     = y_ff;
   assign dn_z     = z_ff;
   assign dn_flags = flags_ff;

endmodule

>>> rtl/quadrant_atan2_full_turn.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrant_atan2_full_turn: pipelined four-quadrant arctangent
// Fixed-length CORDIC vectoring that returns atan2(y, x) as an unsigned
// binary angle in [0, full turn), one stage per micro-rotation.
// ----------------------------------------------------------------------------
// The block takes one (x, y) item per cycle while the output side keeps up
// and returns one angle per item, in order, through one fold stage, one
// register stage per CORDIC micro-rotation and one rounding stage.
// Throughput is one item per cycle unless the output stalls; every stage has
// its own valid bit and a stage accepts whenever it is empty or its
// successor takes its item, so a stalled output lets the pipe fill up
// behind it before the input side sees backpressure. A full turn is
// 2^ANGLE_WIDTH units. Origin and both axes give fixed angles (0, quarter,
// half, three quarter turns); all other results are accurate to a few LSB.
module quadrant_atan2_full_turn #(
   parameter int INPUT_WIDTH = 24,
   parameter int ANGLE_WIDTH = 20,
   parameter int ITERATIONS  = 20
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // fields from bit 0 up: x_value[INPUT_WIDTH], y_value[INPUT_WIDTH], zero pad
   input  logic [((2*INPUT_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // fields from bit 0 up: angle[ANGLE_WIDTH], zero pad
   output logic [((ANGLE_WIDTH+7)/8)*8-1:0] rsp_tdata
);
   import qatan_pkg::*;

   // room for the sign, the fold of the most negative value, the preshift
   // and the CORDIC gain times the diagonal
   localparam int DW     = INPUT_WIDTH + PRESHIFT + 3;
   localparam int RSP_W  = ((ANGLE_WIDTH + 7) / 8) * 8;
   localparam int DROP   = ANGLE_BITS - ANGLE_WIDTH;

   // ---------------------------------------------------------------- fold
   logic signed [INPUT_WIDTH-1:0] x_raw;
   logic signed [INPUT_WIDTH-1:0] y_raw;
   logic signed [DW-1:0]          x_ext;
   logic signed [DW-1:0]          y_ext;
   logic signed [DW-1:0]          s0_x_ff, s0_x_in;
   logic signed [DW-1:0]          s0_y_ff, s0_y_in;
   qatan_flags_type               s0_flags_ff, s0_flags_in;
   logic                          s0_valid_ff;
   logic                          s0_ready;

   // pipeline taps: index k feeds micro-rotation k
   logic                  pipe_valid [ITERATIONS+1];
   logic                  pipe_ready [ITERATIONS+1];
   logic signed [DW-1:0]  pipe_x     [ITERATIONS+1];
   logic signed [DW-1:0]  pipe_y     [ITERATIONS+1];
   logic [ANGLE_BITS-1:0] pipe_z     [ITERATIONS+1];
   qatan_flags_type       pipe_flags [ITERATIONS+1];

   assign x_raw = req_tdata[INPUT_WIDTH-1:0];
   assign y_raw = req_tdata[2*INPUT_WIDTH-1:INPUT_WIDTH];

   always_comb begin
      x_ext = DW'(x_raw);
      y_ext = DW'(y_raw);
      // fold the left half plane onto the right one: negate both, add a half turn
      if (x_raw[INPUT_WIDTH-1]) begin
         s0_x_in = (-x_ext) <<< PRESHIFT;
         s0_y_in = (-y_ext) <<< PRESHIFT;
      end else begin
         s0_x_in = x_ext <<< PRESHIFT;
         s0_y_in = y_ext <<< PRESHIFT;
      end
      s0_flags_in.half     = x_raw[INPUT_WIDTH-1];
      s0_flags_in.special  = 1'b0;
      s0_flags_in.quarters = 2'd0;
      // origin and axes take fixed angles
      if (x_raw == '0) begin
         s0_flags_in.special = 1'b1;
         if (y_raw[INPUT_WIDTH-1]) begin
            s0_flags_in.quarters = 2'd3;
         end else if (y_raw != '0) begin
            s0_flags_in.quarters = 2'd1;
         end
      end else if (y_raw == '0) begin
         s0_flags_in.special = 1'b1;
         if (x_raw[INPUT_WIDTH-1]) begin
            s0_flags_in.quarters = 2'd2;
         end
      end
   end

   assign s0_ready   = !s0_valid_ff || pipe_ready[0];
   assign req_tready = s0_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (s0_ready) begin
         s0_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_ready && req_tvalid) begin
         s0_x_ff     <= s0_x_in;
         s0_y_ff     <= s0_y_in;
         s0_flags_ff <= s0_flags_in;
      end
   end

   assign pipe_valid[0] = s0_valid_ff;
   assign pipe_x[0]     = s0_x_ff;
   assign pipe_y[0]     = s0_y_ff;
   assign pipe_z[0]     = '0;
   assign pipe_flags[0] = s0_flags_ff;

   // ------------------------------------------------------ micro-rotations
   for (genvar k = 0; k < ITERATIONS; k++) begin : g_rot
      qatan_stage #(
         .DATA_WIDTH(DW),
         .SHIFT     (k)
      ) u_stage (
         .clock   (clock),
         .reset   (reset),
         .up_valid(pipe_valid[k]),
         .up_ready(pipe_ready[k]),
         .up_x    (pipe_x[k]),
         .up_y    (pipe_y[k]),
         .up_z    (pipe_z[k]),
         .up_flags(pipe_flags[k]),
         .dn_valid(pipe_valid[k+1]),
         .dn_ready(pipe_ready[k+1]),
         .dn_x    (pipe_x[k+1]),
         .dn_y    (pipe_y[k+1]),
         .dn_z    (pipe_z[k+1]),
         .dn_flags(pipe_flags[k+1])
      );
   end

   // ------------------------------------------------------------ rounding
   logic                   rsp_valid_ff;
   logic                   out_ready;
   logic [ANGLE_WIDTH-1:0] angle_ff, angle_in;
   logic [ANGLE_WIDTH-1:0] angle_calc;
   logic [ANGLE_BITS-1:0]  turn_sum;
   qatan_flags_type        last_flags;

   assign last_flags = pipe_flags[ITERATIONS];
   // add the half-turn offset modulo a full turn
   assign turn_sum = pipe_z[ITERATIONS] + {last_flags.half, {(ANGLE_BITS-1){1'b0}}};

   if (DROP > 0) begin : g_round
      localparam logic [ANGLE_BITS:0] ROUND_HALF = (ANGLE_BITS+1)'(1) << (DROP - 1);
      logic [ANGLE_BITS:0] rounded;
      // round half up, then drop the low bits; a carry out wraps to zero
      assign rounded    = {1'b0, turn_sum} + ROUND_HALF;
      assign angle_calc = rounded[DROP +: ANGLE_WIDTH];
   end else begin : g_full
      assign angle_calc = turn_sum[ANGLE_WIDTH-1:0];
   end

   always_comb begin
      if (last_flags.special) begin
         angle_in = {last_flags.quarters, {(ANGLE_WIDTH-2){1'b0}}};
      end else begin
         angle_in = angle_calc;
      end
   end

   // the output register keeps the result until the sink takes it
   assign out_ready              = !rsp_valid_ff || rsp_tready;
   assign pipe_ready[ITERATIONS] = out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= pipe_valid[ITERATIONS];
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && pipe_valid[ITERATIONS]) begin
         angle_ff <= angle_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'(angle_ff);

`ifndef NO_ASSERTIONS
   // origin item must be flagged as a fixed zero angle after the fold
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && x_raw == '0 && y_raw == '0
      |=> s0_flags_ff.special && s0_flags_ff.quarters == 2'd0)
      else $error("origin item not flagged as zero angle");

   // folded ordinary items must lie strictly in the right half plane
   assert property (@(posedge clock) disable iff (reset)
      s0_valid_ff && !s0_flags_ff.special |-> !s0_x_ff[DW-1] && s0_x_ff != '0)
      else $error("fold left a non-positive x");

   // a fixed angle is a whole number of quarter turns
   assert property (@(posedge clock) disable iff (reset)
      out_ready && pipe_valid[ITERATIONS] && last_flags.special
      |=> rsp_tvalid && angle_ff[ANGLE_WIDTH-3:0] == '0)
      else $error("fixed angle not a quarter-turn multiple");

   // no result is shown right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !s0_valid_ff)
      else $error("valid state survived reset");
`endif

endmodule
